// ===== rtl/core/twcp_pkg.sv =====
`default_nettype none
package twcp_pkg;
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int AMPLITUDE_BITS_DEF = 16;
    localparam int WHEEL_COUNT_DEF    = 3;
    localparam int MAX_WHEELS         = 3;
    localparam int OUT_BITS           = 18;
    localparam int CORDIC_STEPS       = 16;
    localparam int CW                 = 34;
    localparam int ZW                 = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_AMP1  = 3'd1;
    localparam logic [2:0] REG_AMP3  = 3'd3;
    localparam logic [2:0] REG_RP1   = 3'd4;
    localparam logic [2:0] REG_RP3   = 3'd6;

    function automatic logic signed [ZW-1:0] atan_turns(input int k);
        logic signed [ZW-1:0] v;
        unique case (k)
            0: v = 34'sd536870912;  1: v = 34'sd316933406;
            2: v = 34'sd167458907;  3: v = 34'sd85004756;
            4: v = 34'sd42667331;   5: v = 34'sd21354465;
            6: v = 34'sd10679838;   7: v = 34'sd5340245;
            8: v = 34'sd2670163;    9: v = 34'sd1335087;
            10: v = 34'sd667544;    11: v = 34'sd333772;
            12: v = 34'sd166886;    13: v = 34'sd83443;
            14: v = 34'sd41721;     default: v = 34'sd20861;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           q;
    } t_rot;
endpackage
`default_nettype wire

// ===== rtl/core/twcp_stream_if.sv =====
`default_nettype none
interface twcp_stream_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/three_wheel_curve_point.sv =====
`default_nettype none
// channel   | dir | payload
// ----------+-----+-----------------------------------------
// s_in      | in  | sample_index[15:0]
// m_out     | out | point_y[35:18] point_x[17:0] last_sample[36]
// cfg       | in  | i_cfg_we, i_cfg_index[2:0], i_cfg_data[31:0]
// One item a cycle while the output is not stalled; the pipeline is set by the
// divider row, the phase stage, the CORDIC cell row and the summing stages.
// The whole pipe advances when the output register is empty or being taken.
// Reset (synchronous) clears valid bits and loads register defaults.
module three_wheel_curve_point import twcp_pkg::*; #(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int AMPLITUDE_BITS = AMPLITUDE_BITS_DEF,
    parameter int WHEEL_COUNT    = WHEEL_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    twcp_stream_if.sink      s_in,
    twcp_stream_if.source    m_out
);
    localparam int DIV_STAGES = 18;
    localparam int LAT = DIV_STAGES + 1 + CORDIC_STEPS + 2 + 2;
    localparam int WN = (WHEEL_COUNT < MAX_WHEELS) ? WHEEL_COUNT : MAX_WHEELS;
    localparam int SH = 24 - ANGLE_BITS;

    logic [15:0] r_count;
    logic signed [AMPLITUDE_BITS-1:0] r_amp [MAX_WHEELS];
    logic [31:0] r_rp [MAX_WHEELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd1024;
            for (int k = 0; k < MAX_WHEELS; k++) begin
                r_amp[k] <= '0;
                r_rp[k]  <= '0;
            end
            r_amp[0] <= AMPLITUDE_BITS'(4096);
            r_rp[0]  <= 32'd65536;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COUNT) r_count <= i_cfg_data[15:0];
            else if (i_cfg_index >= 3'(REG_AMP1) && i_cfg_index <= REG_AMP3)
                r_amp[2'(i_cfg_index - REG_AMP1)] <= i_cfg_data[AMPLITUDE_BITS-1:0];
            else if (i_cfg_index >= REG_RP1 && i_cfg_index <= REG_RP3)
                r_rp[2'(i_cfg_index - REG_RP1)] <= i_cfg_data;
        end
    end

    logic en;
    logic [LAT-1:0] r_vld;
    logic r_ovld;
    assign en = !r_ovld || m_out.ready;
    assign s_in.ready = en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (en) r_vld <= {r_vld[LAT-2:0], s_in.valid};
            if (en) r_ovld <= r_vld[LAT-1];
        end
    end

    // restoring divider row: (i*2^17 + last) / (2*last), 18 quotient bits
    logic [15:0] last;
    assign last = (r_count == 16'd0) ? 16'd0 : r_count - 16'd1;
    logic [33:0] rem [DIV_STAGES+1];
    logic [17:0] quo [DIV_STAGES+1];
    logic [16:0] dv  [DIV_STAGES+1];
    logic        lst [DIV_STAGES+1];
    logic        zer [DIV_STAGES+1];
    always_comb begin
        rem[0] = {1'b0, s_in.data[15:0], 17'd0} + 34'(last);
        quo[0] = '0;
        dv[0]  = {last, 1'b0};
        lst[0] = s_in.data[15:0] >= last;
        zer[0] = last == 16'd0;
    end
    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        logic [33:0] r_rem; logic [17:0] r_quo; logic [16:0] r_dv;
        logic r_l, r_z;
        logic [33:0] tr; logic ge;
        localparam int B = DIV_STAGES - 1 - d;
        always_comb begin
            ge = (rem[d] >> B) >= 34'(dv[d]);
            tr = ge ? rem[d] - (34'(dv[d]) << B) : rem[d];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem <= tr; r_dv <= dv[d]; r_l <= lst[d]; r_z <= zer[d];
                r_quo <= quo[d] | (18'(ge) << B);
            end
        end
        assign rem[d+1] = r_rem; assign quo[d+1] = r_quo; assign dv[d+1] = r_dv;
        assign lst[d+1] = r_l;   assign zer[d+1] = r_z;
    end

    logic [16:0] t;
    assign t = zer[DIV_STAGES] ? 17'd0 :
               lst[DIV_STAGES] ? 17'd65536 : quo[DIV_STAGES][16:0];

    // phase stage: one 16x17 multiply per wheel, registered
    logic [31:0] r_ph [WN];
    logic        r_lst [CORDIC_STEPS+3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < WN; k++) begin
                logic signed [33:0] pr;
                logic [23:0] p24;
                logic [ANGLE_BITS-1:0] pa;
                pr  = $signed(r_rp[k][31:16]) * $signed({1'b0, t});
                p24 = 24'(pr) + {r_rp[k][15:0], 8'd0};
                pa  = ANGLE_BITS'((25'(p24) + 25'((1 << SH) >> 1)) >> SH);
                r_ph[k] <= {pa, {(32-ANGLE_BITS){1'b0}}};
            end
            r_lst[0] <= lst[DIV_STAGES] || zer[DIV_STAGES];
            for (int j = 1; j < CORDIC_STEPS + 3; j++) r_lst[j] <= r_lst[j-1];
        end
    end

    logic signed [15:0] cs [WN];
    logic signed [15:0] sn [WN];
    for (genvar k = 0; k < WN; k++) begin : g_wheel
        twcp_wheel u_wheel (
            .i_clk(i_clk), .i_en(en), .i_phase(r_ph[k]),
            .o_cos(cs[k]), .o_sin(sn[k])
        );
    end

    // products registered, then summed, then rounded into output register
    localparam int PW = AMPLITUDE_BITS + 16;
    localparam int SW = PW + 4;
    logic signed [PW-1:0] r_px [WN];
    logic signed [PW-1:0] r_py [WN];
    logic signed [SW-1:0] r_sx, r_sy;
    logic r_l1, r_l2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < WN; k++) begin
                r_px[k] <= r_amp[k] * cs[k];
                r_py[k] <= r_amp[k] * sn[k];
            end
            r_l1 <= r_lst[CORDIC_STEPS+2];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic signed [SW-1:0] ax, ay;
            ax = '0; ay = '0;
            for (int k = 0; k < WN; k++) begin
                ax = ax + SW'(r_px[k]);
                ay = ay + SW'(r_py[k]);
            end
            r_sx <= ax; r_sy <= ay; r_l2 <= r_l1;
        end
    end
    function automatic logic [OUT_BITS-1:0] rnd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + SW'(16384)) >>> 15;
        if (r > SW'((1 << (OUT_BITS-1)) - 1)) return OUT_BITS'((1 << (OUT_BITS-1)) - 1);
        if (r < -SW'(1 << (OUT_BITS-1))) return OUT_BITS'(1 << (OUT_BITS-1));
        return r[OUT_BITS-1:0];
    endfunction
    logic [36:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) r_out <= {r_l2, rnd(r_sy), rnd(r_sx)};
    end
    assign m_out.valid = r_ovld;
    assign m_out.data  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_out.ready |=> r_ovld && $stable(r_out)) else $error("out lost");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[LAT-1] |=> r_ovld) else $error("item dropped");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> s_in.ready) else $error("stalled while empty");
endmodule
`default_nettype wire

// ===== rtl/core/twcp_cell.sv =====
`default_nettype none
// One CORDIC micro-rotation per cell; a row of these forms the rotator.
module twcp_cell import twcp_pkg::*; #(
    parameter int STEP = 0
) (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_rot i_rot,
    output t_rot      o_rot
);
    t_rot n_rot, r_rot;
    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[ZW-1]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STEP);
            n_rot.y = i_rot.y + (i_rot.x >>> STEP);
            n_rot.z = i_rot.z - atan_turns(STEP);
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STEP);
            n_rot.y = i_rot.y - (i_rot.x >>> STEP);
            n_rot.z = i_rot.z + atan_turns(STEP);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_rot <= n_rot;
    end
    assign o_rot = r_rot;
endmodule
`default_nettype wire

// ===== rtl/core/twcp_wheel.sv =====
`default_nettype none
// Phase in, Q1.15 cos and sin out, through in register, cell row and out register.
module twcp_wheel import twcp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [31:0]       i_phase,
    output logic signed [15:0]     o_cos,
    output logic signed [15:0]     o_sin
);
    t_rot chain [CORDIC_STEPS+1];
    t_rot r_in;
    logic [1:0] q;
    logic signed [ZW-1:0] z;

    always_comb begin
        q = 2'(({2'b00, i_phase} + 34'h020000000) >> 30);
        z = $signed({2'b00, i_phase}) - $signed({2'b00, q, 30'd0});
        if (z >= 34'sh080000000) z = z - 34'sh100000000;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in.x <= CORDIC_X0;
            r_in.y <= '0;
            r_in.z <= z;
            r_in.q <= q;
        end
    end
    assign chain[0] = r_in;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        twcp_cell #(.STEP(k)) u_cell (
            .i_clk(i_clk), .i_en(i_en), .i_rot(chain[k]), .o_rot(chain[k+1])
        );
    end

    t_rot f;
    logic signed [CW-1:0] xn, yn, xr, yr;
    assign f = chain[CORDIC_STEPS];
    always_comb begin
        unique case (f.q)
            2'd0: begin xn = f.x;  yn = f.y;  end
            2'd1: begin xn = -f.y; yn = f.x;  end
            2'd2: begin xn = -f.x; yn = -f.y; end
            default: begin xn = f.y; yn = -f.x; end
        endcase
        xr = (xn + CW'(16384)) >>> 15;
        yr = (yn + CW'(16384)) >>> 15;
    end
    function automatic logic signed [15:0] sat15(input logic signed [CW-1:0] v);
        if (v > 34'sd32767) return 16'sd32767;
        if (v < -34'sd32767) return -16'sd32767;
        return v[15:0];
    endfunction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= sat15(xr);
            o_sin <= sat15(yr);
        end
    end
endmodule
`default_nettype wire
